// ----- hdl/swrr_pkg.sv -----
// Shared types, codes and defaults of the smooth weighted round-robin scheduler.
package swrr_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_WEIGHT_BITS = 8;

    // Fixed port field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int WFIELD_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Running weight is a 16-bit two's complement value
    localparam int RW_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_SELECT = 2'd0,
        KIND_HEALTH = 2'd1,
        KIND_LOAD   = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_ENTRIES = 2'd1,
        ST_NO_HEALTHY = 2'd2,
        ST_BAD_INDEX  = 2'd3
    } t_status;

endpackage

// ----- hdl/smooth_weighted_round_robin.sv -----
// Smooth weighted round-robin scheduler: entry table in a one-port-read memory.
//
// Channels:
//   Input (i_in_valid / o_in_ready): one command per transaction: select the
//   next entry, set an entry's health bit, or load an entry's weight and health
//   (a load also clears the entry's running weight).
//   Output (o_out_valid / i_out_ready): one result per command: status, chosen
//   index and chosen static weight.
//   Config (i_cfg_valid / o_cfg_ready): writes entry_count; always ready. The user
//   must write it only while no command is in flight; not enforced by the block.
// Operation (entry_count is clipped to the table depth):
//   A select scans one entry per cycle with a read-add-write-back, then drains
//   the read and writes the winner back before its result goes to the output.
//   Health and load are a read-modify-write of one entry.
//   Error cases (no entries, bad index, unknown kind) go straight to the output.
//   One command at a time; the next is taken in the cycle after the result loads.
// Reset: synchronous, active low. entry_count clears; per-entry valid bits clear
//   so every entry reads as weight 0, running weight 0, unhealthy.
// Stall: a result waits in the output register; the next command is taken
//   meanwhile, but its result waits until the output register is free.
module smooth_weighted_round_robin
    import swrr_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic [WFIELD_W-1:0] i_weight,
    input  logic                i_healthy,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_chosen_index,
    output logic [WFIELD_W-1:0] o_chosen_weight,
    // configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_entry_count
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = CNT_W + COUNT_W + INDEX_W;
    localparam int TOT_W = WEIGHT_BITS + IDX_W;
    localparam int ADD_W = RW_W + 2;
    localparam int DIF_W = ((TOT_W > RW_W) ? TOT_W : RW_W) + 2;

    localparam logic signed [RW_W-1:0] RW_MAX = {1'b0, {(RW_W-1){1'b1}}};
    localparam logic signed [RW_W-1:0] RW_MIN = {1'b1, {(RW_W-1){1'b0}}};

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic signed [RW_W-1:0] rw;
        logic                   health;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_OUT
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [COUNT_W-1:0]      r_entry_count;
    logic [MAX_ENTRIES-1:0]  r_vld;

    // captured command
    t_kind                   r_kind, n_kind;
    logic [INDEX_W-1:0]      r_idx, n_idx;
    logic [WEIGHT_BITS-1:0]  r_w, n_w;
    logic                    r_h, n_h;

    // scan state
    logic [CNT_W-1:0]        r_addr, n_addr;
    logic                    r_pv, n_pv;          // read data returns this cycle
    logic [IDX_W-1:0]        r_proc_addr, n_proc_addr;
    logic                    r_found, n_found;
    logic [IDX_W-1:0]        r_best_addr, n_best_addr;
    logic signed [RW_W-1:0]  r_best_rw, n_best_rw;
    logic [WEIGHT_BITS-1:0]  r_best_w, n_best_w;
    logic [TOT_W-1:0]        r_total, n_total;

    // pending result and output register
    t_status                 r_res_status, n_res_status;
    logic [INDEX_W-1:0]      r_res_idx, n_res_idx;
    logic [WFIELD_W-1:0]     r_res_w, n_res_w;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_o_status, n_o_status;
    logic [INDEX_W-1:0]      r_o_idx, n_o_idx;
    logic [WFIELD_W-1:0]     r_o_w, n_o_w;

    // entry memory
    t_entry                  mem [MAX_ENTRIES];
    t_entry                  r_rd_data;
    logic                    r_rd_hit;

    // memory port controls
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    t_entry                  wr_data;

    // datapath helpers
    logic [CNT_W-1:0]        n_active;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    in_fire;
    logic                    idx_bad;
    t_entry                  rd_entry;
    logic signed [ADD_W-1:0] add_sum;
    logic signed [RW_W-1:0]  add_sat;
    logic signed [DIF_W-1:0] dif_sum;
    logic signed [RW_W-1:0]  dif_sat;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_chosen_index  = r_o_idx;
    assign o_chosen_weight = r_o_w;

    assign in_fire = i_in_valid && o_in_ready;

    // entries in use, clipped to the table depth
    assign cnt_ext  = CMP_W'(r_entry_count);
    assign n_active = (cnt_ext > CMP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                      : CNT_W'(r_entry_count);
    assign idx_bad  = (CMP_W'(i_entry_index) >= CMP_W'(n_active));

    // never-written entries read as all zero
    assign rd_entry = r_rd_hit ? r_rd_data : '0;

    // saturating add of the static weight into the running weight
    assign add_sum = ADD_W'(rd_entry.rw) + $signed(ADD_W'(rd_entry.weight));
    always_comb begin
        if ((&add_sum[ADD_W-1:RW_W-1]) || !(|add_sum[ADD_W-1:RW_W-1])) begin
            add_sat = add_sum[RW_W-1:0];
        end else if (add_sum[ADD_W-1]) begin
            add_sat = RW_MIN;
        end else begin
            add_sat = RW_MAX;
        end
    end

    // saturating subtract of the healthy weight sum from the winner
    assign dif_sum = DIF_W'(r_best_rw) - $signed(DIF_W'(r_total));
    always_comb begin
        if ((&dif_sum[DIF_W-1:RW_W-1]) || !(|dif_sum[DIF_W-1:RW_W-1])) begin
            dif_sat = dif_sum[RW_W-1:0];
        end else if (dif_sum[DIF_W-1]) begin
            dif_sat = RW_MIN;
        end else begin
            dif_sat = RW_MAX;
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_idx        = r_idx;
        n_w          = r_w;
        n_h          = r_h;
        n_addr       = r_addr;
        n_pv         = 1'b0;
        n_proc_addr  = r_proc_addr;
        n_found      = r_found;
        n_best_addr  = r_best_addr;
        n_best_rw    = r_best_rw;
        n_best_w     = r_best_w;
        n_total      = r_total;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_w      = r_res_w;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_idx      = r_o_idx;
        n_o_w        = r_o_w;
        rd_en        = 1'b0;
        rd_addr      = r_addr[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_proc_addr;
        wr_data      = rd_entry;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind = t_kind'(i_kind);
                    n_idx  = i_entry_index;
                    n_w    = WEIGHT_BITS'(i_weight);
                    n_h    = i_healthy;
                    case (t_kind'(i_kind))
                        KIND_SELECT: begin
                            if (n_active == '0) begin
                                n_res_status = ST_NO_ENTRIES;
                                n_res_idx    = '0;
                                n_res_w      = '0;
                                n_state      = S_OUT;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = '0;
                                n_addr      = CNT_W'(1);
                                n_pv        = 1'b1;
                                n_proc_addr = '0;
                                n_found     = 1'b0;
                                n_total     = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        KIND_HEALTH, KIND_LOAD: begin
                            if (idx_bad) begin
                                n_res_status = ST_BAD_INDEX;
                                n_res_idx    = i_entry_index;
                                n_res_w      = '0;
                                n_state      = S_OUT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = IDX_W'(i_entry_index);
                                n_state = S_RMW;
                            end
                        end
                        default: begin
                            n_res_status = ST_BAD_INDEX;
                            n_res_idx    = i_entry_index;
                            n_res_w      = '0;
                            n_state      = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next read while the previous one is processed
                if (r_addr < n_active) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_addr[IDX_W-1:0];
                    n_addr      = r_addr + CNT_W'(1);
                    n_pv        = 1'b1;
                    n_proc_addr = r_addr[IDX_W-1:0];
                end
                if (r_pv) begin
                    if (rd_entry.health) begin
                        wr_en      = 1'b1;
                        wr_addr    = r_proc_addr;
                        wr_data    = rd_entry;
                        wr_data.rw = add_sat;
                        n_total    = r_total + TOT_W'(rd_entry.weight);
                        // strict compare keeps the lowest index on ties
                        if (!r_found || (add_sat > r_best_rw)) begin
                            n_found     = 1'b1;
                            n_best_addr = r_proc_addr;
                            n_best_rw   = add_sat;
                            n_best_w    = rd_entry.weight;
                        end
                    end
                end else begin
                    // scan drained: charge the winner with the weight sum
                    if (!r_found) begin
                        n_res_status = ST_NO_HEALTHY;
                        n_res_idx    = '0;
                        n_res_w      = '0;
                    end else begin
                        wr_en          = 1'b1;
                        wr_addr        = r_best_addr;
                        wr_data.weight = r_best_w;
                        wr_data.rw     = dif_sat;
                        wr_data.health = 1'b1;
                        n_res_status   = ST_OK;
                        n_res_idx      = INDEX_W'(r_best_addr);
                        n_res_w        = WFIELD_W'(r_best_w);
                    end
                    n_state = S_OUT;
                end
            end

            S_RMW: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_idx);
                wr_data = rd_entry;
                wr_data.health = r_h;
                if (r_kind == KIND_LOAD) begin
                    wr_data.weight = r_w;
                    wr_data.rw     = '0;
                    n_res_w        = WFIELD_W'(r_w);
                end else begin
                    n_res_w        = WFIELD_W'(rd_entry.weight);
                end
                n_res_status = ST_OK;
                n_res_idx    = r_idx;
                n_state      = S_OUT;
            end

            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_idx     = r_res_idx;
                    n_o_w       = r_res_w;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_vld         <= '0;
            r_pv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_entry_count;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
        r_kind       <= n_kind;
        r_idx        <= n_idx;
        r_w          <= n_w;
        r_h          <= n_h;
        r_addr       <= n_addr;
        r_proc_addr  <= n_proc_addr;
        r_found      <= n_found;
        r_best_addr  <= n_best_addr;
        r_best_rw    <= n_best_rw;
        r_best_w     <= n_best_w;
        r_total      <= n_total;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_w      <= n_res_w;
        r_o_status   <= n_o_status;
        r_o_idx      <= n_o_idx;
        r_o_w        <= n_o_w;
    end

    // ------------------------------------------------------------------
    // Entry memory: one write, one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_hit  <= r_vld[rd_addr];
        end
    end

endmodule

// ----- tb/sv/tb_smooth_weighted_round_robin.sv -----
// Self-checking testbench for the smooth weighted round-robin scheduler.
module tb_smooth_weighted_round_robin;
    import swrr_pkg::*;

    localparam int TBL_DEPTH = DEF_MAX_ENTRIES;
    // Kind code with no operation behind it; the block must reject it
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    // A select scans every entry in use before it answers, so allow some margin
    localparam int SETTLE_CYCLES  = 24;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  idx;
        logic [WFIELD_W-1:0] wt;
        logic                hl;
        logic                hold;   // sender waits for all results before this one
    } t_command;

    typedef struct packed {
        t_status             status;
        logic [INDEX_W-1:0]  index;
        logic [WFIELD_W-1:0] weight;
    } t_grant;

    // ------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------
    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_in_valid        = 1'b0;
    logic                o_in_ready;
    logic [KIND_W-1:0]   i_kind            = '0;
    logic [INDEX_W-1:0]  i_entry_index     = '0;
    logic [WFIELD_W-1:0] i_weight          = '0;
    logic                i_healthy         = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready       = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_chosen_index;
    logic [WFIELD_W-1:0] o_chosen_weight;
    logic                i_cfg_valid       = 1'b0;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_entry_count = '0;

    smooth_weighted_round_robin u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_entry_index     (i_entry_index),
        .i_weight          (i_weight),
        .i_healthy         (i_healthy),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_chosen_index    (o_chosen_index),
        .o_chosen_weight   (o_chosen_weight),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_entry_count (i_cfg_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scheduler state as the testbench sees it
    // ------------------------------------------------------------------
    int unsigned        entries_in_use = 0;   // raw register value, clamped on use
    logic [WFIELD_W-1:0] weight_tbl [TBL_DEPTH];
    int                  run_wt     [TBL_DEPTH];
    bit                  health_bit [TBL_DEPTH];

    t_command    cmd_q[$];       // commands waiting for the driver
    t_grant      grant_q[$];     // predicted results, oldest first
    t_command    cmd_in_flight;  // payload currently offered on the input channel

    int unsigned queued_total = 0;   // commands handed to the driver
    int unsigned sent_cnt     = 0;   // input transactions (NBA only)
    int unsigned recv_cnt     = 0;   // output transactions (NBA only)
    int unsigned mismatches   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned n_select = 0, n_health = 0, n_load = 0, n_granted = 0, n_rejected = 0;

    // Idle behavior, changed by the sequencer only while the block is quiet
    int unsigned stall_mode = 0;
    bit          gaps_on    = 1'b0;

    function automatic int clamp_rw(longint v);
        if (v > 32767)  return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // Applies one command to the local copy of the table and returns the result
    // that the block has to produce for it.
    function automatic t_grant schedule_next(t_command c);
        t_grant      g;
        int unsigned n;
        int          i;
        int          lead;
        int          lead_rw;
        int          sum;
        bit          found;
        g.status = ST_OK;
        g.index  = c.idx;
        g.weight = '0;
        n = (entries_in_use > TBL_DEPTH) ? TBL_DEPTH : entries_in_use;
        lead = 0;
        lead_rw = 0;
        sum = 0;
        found = 1'b0;
        if (c.kind == KIND_SELECT) begin
            g.index = '0;
            if (n == 0) begin
                g.status = ST_NO_ENTRIES;
            end else begin
                for (i = 0; i < n; i++) begin
                    if (!health_bit[i]) continue;
                    run_wt[i] = clamp_rw(longint'(run_wt[i]) + int'(weight_tbl[i]));
                    sum += int'(weight_tbl[i]);
                    // strict compare keeps the lowest index on a tie
                    if (!found || run_wt[i] > lead_rw) begin
                        found   = 1'b1;
                        lead_rw = run_wt[i];
                        lead    = i;
                    end
                end
                if (!found) begin
                    g.status = ST_NO_HEALTHY;
                end else begin
                    run_wt[lead] = clamp_rw(longint'(run_wt[lead]) - sum);
                    g.index  = lead[INDEX_W-1:0];
                    g.weight = weight_tbl[lead];
                end
            end
        end else if (c.kind == KIND_HEALTH || c.kind == KIND_LOAD) begin
            if (c.idx >= n) begin
                g.status = ST_BAD_INDEX;
            end else begin
                if (c.kind == KIND_LOAD) begin
                    weight_tbl[c.idx] = c.wt;
                    run_wt[c.idx]     = 0;
                end
                health_bit[c.idx] = c.hl;
                g.weight = weight_tbl[c.idx];
            end
        end else begin
            g.status = ST_BAD_INDEX;
        end
        return g;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: %0s", msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions from cmd_q; while gaps_on is set, random gaps between them
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        t_command    nxt;
        t_grant      g;
        bit          fire;
        int unsigned sent_now;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            sent_cnt   <= 0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            fire     = i_in_valid && o_in_ready;
            sent_now = sent_cnt + (fire ? 1 : 0);
            if (fire) begin
                g = schedule_next(cmd_in_flight);
                grant_q = {grant_q, g};
                sent_cnt <= sent_now;
                case (cmd_in_flight.kind)
                    KIND_SELECT: n_select++;
                    KIND_HEALTH: n_health++;
                    KIND_LOAD:   n_load++;
                    default:     ;
                endcase
                if (g.status == ST_OK && cmd_in_flight.kind == KIND_SELECT) n_granted++;
                if (g.status != ST_OK) n_rejected++;
            end
            // Payload only moves once the current transaction is done
            if (fire || !i_in_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (cmd_q.size() == 0 ||
                             (cmd_q[0].hold && sent_now != recv_cnt)) begin
                    // recv_cnt is updated by NBA, so it trails the handshake
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = cmd_q.pop_front();
                    cmd_in_flight  = nxt;
                    i_in_valid    <= 1'b1;
                    i_kind        <= nxt.kind;
                    i_entry_index <= nxt.idx;
                    i_weight      <= nxt.wt;
                    i_healthy     <= nxt.hl;
                    if (burst_left == 0) burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0 && gaps_on) gap_left = $urandom_range(1, 10);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction, stalls on its own pattern
    // ------------------------------------------------------------------
    int unsigned stall_tick = 0;

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_cnt    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                recv_cnt <= recv_cnt + 1;
                if (grant_q.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing pending", recv_cnt));
                end else begin
                    want = grant_q.pop_front();
                    if (o_status !== want.status || o_chosen_index !== want.index ||
                        o_chosen_weight !== want.weight)
                        flag_mismatch($sformatf(
                            "result %0d: want st=%0d idx=%0d w=%0d, got st=%0d idx=%0d w=%0d",
                            recv_cnt, want.status, want.index, want.weight,
                            o_status, o_chosen_index, o_chosen_weight));
                end
            end
            stall_tick++;
            case (stall_mode)
                0:       i_out_ready <= 1'b1;                          // never stalls
                1:       i_out_ready <= 1'($urandom_range(0, 1));      // coin flip
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                default: i_out_ready <= ((stall_tick % 7) >= 3);       // fixed duty
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no channel moves for too long
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. Queue updates happen at the falling edge so the driver,
    // which pops at the rising edge, never races them.
    // ------------------------------------------------------------------
    task automatic queue_command(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                 logic [WFIELD_W-1:0] wt, logic hl, logic hold = 1'b0);
        t_command c;
        c.kind = kind;
        c.idx  = idx;
        c.wt   = wt;
        c.hl   = hl;
        c.hold = hold;
        cmd_q = {cmd_q, c};
        queued_total++;
    endtask

    // Every command answered, then a pause for anything still in the pipe
    task automatic wait_idle();
        do @(negedge i_clk); while (sent_cnt != queued_total || recv_cnt != sent_cnt);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_entry_count(logic [COUNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_entry_count <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        entries_in_use = 32'(v);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    function automatic logic [WFIELD_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return WFIELD_W'($urandom_range(1, 3));
            default: return WFIELD_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One configuration setting: load every entry in use, then a random mix in
    // which selects dominate if entries are in use, so the running weights move.
    task automatic run_phase(int unsigned count_val, int unsigned n_items, bit calm);
        int unsigned n;
        int unsigned k;
        int unsigned r;
        logic        hold;
        write_entry_count(COUNT_W'(count_val));
        n = (count_val > TBL_DEPTH) ? TBL_DEPTH : count_val;
        stall_mode = calm ? 0 : $urandom_range(0, 3);
        gaps_on    = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
        for (k = 0; k < n; k++)
            queue_command(KIND_LOAD, INDEX_W'(k), pick_weight(), $urandom_range(0, 4) != 0);
        for (k = n; k < n_items; k++) begin
            r    = $urandom_range(0, 99);
            hold = ($urandom_range(0, 49) == 0);
            if (n == 0) begin
                queue_command(KIND_W'($urandom_range(0, 3)), INDEX_W'($urandom_range(0, 15)),
                              WFIELD_W'($urandom), 1'($urandom_range(0, 1)), hold);
            end else if (r < 55) begin
                queue_command(KIND_SELECT, INDEX_W'($urandom_range(0, 15)),
                              WFIELD_W'($urandom), 1'($urandom_range(0, 1)), hold);
            end else if (r < 70) begin
                queue_command(KIND_HEALTH, INDEX_W'($urandom_range(0, n - 1)),
                              WFIELD_W'($urandom), $urandom_range(0, 3) != 0, hold);
            end else if (r < 85) begin
                queue_command(KIND_LOAD, INDEX_W'($urandom_range(0, n - 1)),
                              pick_weight(), $urandom_range(0, 3) != 0, hold);
            end else if (r < 93 && n < TBL_DEPTH) begin
                // address past the entries in use
                queue_command(($urandom_range(0, 1) != 0) ? KIND_LOAD : KIND_HEALTH,
                              INDEX_W'($urandom_range(n, 15)), WFIELD_W'($urandom),
                              1'($urandom_range(0, 1)), hold);
            end else begin
                queue_command(KIND_UNKNOWN, INDEX_W'($urandom_range(0, 15)),
                              WFIELD_W'($urandom), 1'($urandom_range(0, 1)), hold);
            end
        end
        wait_idle();
    endtask

    initial begin
        int unsigned counts[14];
        int          j;
        for (j = 0; j < TBL_DEPTH; j++) begin
            weight_tbl[j] = '0;
            run_wt[j]     = 0;
            health_bit[j] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, every kind rejected or reported
        write_entry_count(COUNT_W'(0));
        queue_command(KIND_SELECT,  4'd0,  8'h00, 1'b0);
        queue_command(KIND_HEALTH,  4'd0,  8'h00, 1'b1);
        queue_command(KIND_LOAD,    4'd15, 8'hFF, 1'b1);
        queue_command(KIND_UNKNOWN, 4'd9,  8'hAA, 1'b1);
        wait_idle();

        // Directed: full table, no healthy entry yet, then weight and health edges
        write_entry_count(COUNT_W'(TBL_DEPTH));
        queue_command(KIND_SELECT,  4'd3,  8'h5A, 1'b1);   // nothing healthy
        queue_command(KIND_LOAD,    4'd0,  8'hFF, 1'b1);
        queue_command(KIND_LOAD,    4'd15, 8'h00, 1'b1);   // healthy but zero weight
        queue_command(KIND_LOAD,    4'd7,  8'h55, 1'b0);
        queue_command(KIND_HEALTH,  4'd7,  8'h00, 1'b1);
        queue_command(KIND_HEALTH,  4'd15, 8'hFF, 1'b0);
        queue_command(KIND_HEALTH,  4'd15, 8'h00, 1'b1);
        repeat (4) queue_command(KIND_SELECT, 4'd0, 8'h00, 1'b0);
        queue_command(KIND_UNKNOWN, 4'd15, 8'hFF, 1'b0);
        queue_command(KIND_LOAD,    4'd3,  8'h01, 1'b1, 1'b1);   // sender drains first
        queue_command(KIND_SELECT,  4'd15, 8'hFF, 1'b1);
        queue_command(KIND_SELECT,  4'd0,  8'h00, 1'b0);
        wait_idle();

        // Random settings; 31 exercises the top register bit and must clamp
        counts = '{16, 1, 2, 31, 5, 0, 16, 8, 3, 12, 16, 7, 0, 0};
        counts[12] = $urandom_range(1, TBL_DEPTH);
        counts[13] = $urandom_range(1, TBL_DEPTH);
        for (j = 0; j < 14; j++)
            run_phase(counts[j], (counts[j] == 0) ? 20 : 110, j == 0);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("summary: %0d commands (%0d select, %0d health, %0d load), %0d results checked",
                 sent_cnt, n_select, n_health, n_load, recv_cnt);
        $display("summary: %0d grants, %0d error results, %0d entry_count writes",
                 n_granted, n_rejected, cfg_writes);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
